// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/pat_pkg.sv =====
// ---------------------------------------------------------------------------
// pat_pkg
// Types, constants and helpers for the point-add range-sum tree.
// ---------------------------------------------------------------------------
package pat_pkg;

    localparam int KEY_W = 10;
    localparam int VAL_W = 16;
    localparam int SUM_W = 48;
    localparam int OP_W  = 2;
    localparam int IDX_W = 22;  // level index for the largest key domain

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic             add;
        logic             qry;
        logic [IDX_W-1:0] l;     // key for add, left bound for query
        logic [IDX_W-1:0] r;     // exclusive right bound for query
        logic [VAL_W-1:0] value;
        logic [SUM_W-1:0] acc;
    } t_tok;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/pat_cell.sv =====
// ---------------------------------------------------------------------------
// pat_cell
// One tree level: node store, read stage, update and hand-on to next level.
// ---------------------------------------------------------------------------
module pat_cell import pat_pkg::*; #(
    parameter int LVL = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic [IDX_W-1:0] i_clr_addr,
    input  t_tok             i_tok,
    input  logic             i_vld,
    output t_tok             o_tok,
    output logic             o_vld
);

    localparam int AW = (LVL == 0) ? 1 : LVL;

    logic [SUM_W-1:0] mem [0:(1<<AW)-1];

    t_tok             r_tok1, r_tok2;
    logic             r_v1, r_v2;
    logic [SUM_W-1:0] r_rda, r_rdb;

    logic             active, add_l, add_r;
    logic [SUM_W-1:0] s1, s2;
    logic [IDX_W-1:0] l2, r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
        r_tok1 <= i_tok;
        r_tok2 <= r_tok1;
    end

    always_ff @(posedge i_clk) begin
        r_rda <= mem[r_tok1.l[AW-1:0]];
        r_rdb <= mem[r_tok1.r[AW-1:0] & ~AW'(1)];
        if (i_clr) begin
            mem[i_clr_addr[AW-1:0]] <= '0;
        end else if (r_v2 && r_tok2.add) begin
            mem[r_tok2.l[AW-1:0]] <= sat_add(r_rda, SUM_W'(r_tok2.value));
        end
    end

    always_comb begin
        active = r_tok2.qry && (r_tok2.l < r_tok2.r);
        add_l  = active && r_tok2.l[0];
        add_r  = active && r_tok2.r[0];
        s1     = sat_add(r_tok2.acc, add_l ? r_rda : '0);
        s2     = sat_add(s1, add_r ? r_rdb : '0);
        l2     = r_tok2.l + IDX_W'(add_l);
        r2     = r_tok2.r - IDX_W'(add_r);
        o_tok       = r_tok2;
        o_tok.l     = l2 >> 1;
        o_tok.r     = r2 >> 1;
        o_tok.acc   = s2;
        o_vld       = r_v2;
    end

endmodule

// ===== rtl/point_add_range_sum_tree.sv =====
// ---------------------------------------------------------------------------
// point_add_range_sum_tree
// Saturating point-add, range-sum tree built as a chain of level cells.
// ---------------------------------------------------------------------------
// channel   direction  handshake             payload
// command   in         start & !busy         i_operation i_key_low i_key_high i_value
// result    out        o_valid strobe        o_range_sum
//
// An add or query walks leaf level to root, through the read stage and update
// stage of each level cell, one node read pair per level.
// Empty or out-of-domain queries answer 0 on the next cycle.
// Reset and clear run a sweep that zeroes the node stores, with busy high.
// Results cannot be stalled; one transaction is in flight at a time.
// ---------------------------------------------------------------------------
module point_add_range_sum_tree import pat_pkg::*; #(
    parameter int KEYS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [KEY_W-1:0] i_key_low,
    input  logic [KEY_W-1:0] i_key_high,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    output logic [SUM_W-1:0] o_range_sum
);

    localparam int LV = (KEYS <= 2) ? 1 : $clog2(KEYS);
    localparam int P  = 1 << LV;

    t_tok             tok [0:LV+1];
    logic             vld [0:LV+1];

    logic             r_busy, r_clr, r_out_v;
    logic [LV-1:0]    r_cnt;
    logic [SUM_W-1:0] r_sum;

    logic             acc_ok, lo_in, launch, zero_q;
    logic [IDX_W-1:0] lo, hi, hi_c;

    assign busy        = r_busy | r_clr;
    assign o_valid     = r_out_v;
    assign o_range_sum = r_sum;

    always_comb begin
        acc_ok = start && !busy;
        lo     = IDX_W'(i_key_low);
        hi     = IDX_W'(i_key_high);
        lo_in  = lo < IDX_W'(KEYS);
        hi_c   = (hi < IDX_W'(KEYS)) ? hi : IDX_W'(KEYS - 1);
        launch = 1'b0;
        zero_q = 1'b0;
        tok[0]       = '0;
        tok[0].value = i_value;
        tok[0].l     = lo;
        case (i_operation)
            OP_ADD: begin
                tok[0].add = 1'b1;
                launch     = acc_ok && lo_in;
            end
            OP_QUERY: begin
                tok[0].qry = 1'b1;
                tok[0].r   = hi_c + IDX_W'(1);
                launch     = acc_ok && lo_in && (lo <= hi_c);
                zero_q     = acc_ok && !(lo_in && (lo <= hi_c));
            end
            default: begin
            end
        endcase
        vld[0] = launch;
    end

    for (genvar k = 0; k <= LV; k++) begin : g_cell
        pat_cell #(.LVL(LV - k)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clr      (r_clr),
            .i_clr_addr (IDX_W'(r_cnt)),
            .i_tok      (tok[k]),
            .i_vld      (vld[k]),
            .o_tok      (tok[k+1]),
            .o_vld      (vld[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_clr   <= 1'b1;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (launch) begin
                r_busy <= 1'b1;
            end else if (vld[LV+1]) begin
                r_busy <= 1'b0;
            end
            if (acc_ok && i_operation == OP_CLEAR) begin
                r_clr <= 1'b1;
                r_cnt <= '0;
            end else if (r_clr) begin
                r_cnt <= r_cnt + LV'(1);
                if (r_cnt == LV'(P - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_out_v <= zero_q || (vld[LV+1] && tok[LV+1].qry);
        end
        r_sum <= zero_q ? '0 : tok[LV+1].acc;
    end

endmodule

// ===== rtl/pat_checker.sv =====
// ---------------------------------------------------------------------------
// pat_checker
// Port-level checks on the range-sum tree, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pat_checker import pat_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [OP_W-1:0]  i_operation,
    input logic [KEY_W-1:0] i_key_low,
    input logic [KEY_W-1:0] i_key_high,
    input logic             o_valid,
    input logic [SUM_W-1:0] o_range_sum
);

    logic acc, empty_q;
    assign acc     = start && !busy;
    assign empty_q = acc && i_operation == OP_QUERY && i_key_low > i_key_high;

    `AST_NEXT_ALWAYS(a_rst_clears, i_clk, !i_rst_n, busy)
    `AST_NEXT(a_clear_busy, i_clk, i_rst_n, acc && i_operation == OP_CLEAR, busy)
    `AST_NEXT(a_empty_zero, i_clk, i_rst_n, empty_q, o_valid && o_range_sum == '0)
    `AST_NEXT(a_add_silent, i_clk, i_rst_n, acc && i_operation == OP_ADD, !o_valid)

endmodule

bind point_add_range_sum_tree pat_checker u_pat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .i_key_low   (i_key_low),
    .i_key_high  (i_key_high),
    .o_valid     (o_valid),
    .o_range_sum (o_range_sum)
);
